// ===== hw/rtl/casp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the cave smoothing pass.
// No dependencies; every other file of the block depends on this package.
package casp_pkg;

  // Grid limits and derived widths
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int COL_W    = $clog2(MAX_COLS);      // column position
  localparam int ROW_W    = $clog2(MAX_ROWS + 3);  // row position, holds height plus two
  localparam int SIZE_W   = 9;                     // grid_width / grid_height registers
  localparam int THR_W    = 4;                     // wall_threshold register
  localparam int OUT_W    = 8;                     // out_row / out_col fields
  localparam int CNT_W    = 4;                     // neighbor count, 0..8
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Reset values of the registers
  localparam logic [SIZE_W-1:0] RESET_SIZE      = SIZE_W'(150);
  localparam logic [THR_W-1:0]  RESET_THRESHOLD = THR_W'(4);

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH     = 2'd0,
    REG_GRID_HEIGHT    = 2'd1,
    REG_WALL_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Position-derived info for one accepted item
  typedef struct packed {
    logic [COL_W-1:0] ic;        // column address into the line stores
    logic             bot;       // new bottom bit of the column
    logic             mid_en;    // middle row lies inside the grid
    logic             top_en;    // top row lies inside the grid
    logic             col_zero;  // item opens a row: finish the row before
    logic             emit;      // item produces a word
    logic             fin;       // item produces the final cell of the grid
    logic [OUT_W-1:0] out_row;
    logic [OUT_W-1:0] out_col;
  } pos_t;

  // One line-store entry: bits of the two previous rows at a column
  typedef struct packed {
    logic upper;
    logic lower;
  } line_word_t;

  // One result word
  typedef struct packed {
    logic             new_cell;
    logic [OUT_W-1:0] out_row;
    logic [OUT_W-1:0] out_col;
    logic             last;
  } res_t;

  // Zero acts as one, values above the maximum act as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ===== hw/rtl/casp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the cave smoothing pass: cells in,
// results out, configuration writes. Depends on casp_pkg.
interface casp_cell_if;
  logic valid;
  logic ready;
  logic kind;
  logic cell_req;
  modport source (output valid, output kind, output cell_req, input ready);
  modport sink   (input valid, input kind, input cell_req, output ready);
endinterface

interface casp_res_if;
  logic                      valid;
  logic                      ready;
  logic                      new_cell;
  logic [casp_pkg::OUT_W-1:0] out_row;
  logic [casp_pkg::OUT_W-1:0] out_col;
  logic                      last;
  modport source (output valid, output new_cell, output out_row, output out_col,
                  output last, input ready);
  modport sink   (input valid, input new_cell, input out_row, input out_col,
                  input last, output ready);
endinterface

interface casp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [casp_pkg::CFG_IDX_W-1:0]  index;
  logic [casp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/casp_pos.sv =====
`timescale 1ns / 1ps
// Raster position tracker: input row/column counters, frame wrap and the
// per-item emit/last decisions. Depends on casp_pkg.
module casp_pos (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [casp_pkg::SIZE_W-1:0]   grid_width,
  input  logic [casp_pkg::SIZE_W-1:0]   grid_height,
  input  logic                          kind,
  input  logic                          cell_req,
  input  logic                          accept,
  output casp_pkg::pos_t                info
);
  import casp_pkg::*;

  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [SIZE_W-1:0] w, h;
  logic              col_wrap, restart;
  logic [ROW_W-1:0]  row_a, ir;
  logic [COL_W-1:0]  ic;
  logic [ROW_W:0]    h_p1;
  logic [SIZE_W-1:0] col_inc;
  logic [ROW_W-1:0]  ir_m1, ir_m2;
  logic [SIZE_W-1:0] w_m1;

  assign w = clamp_size(grid_width,  SIZE_W'(MAX_COLS));
  assign h = clamp_size(grid_height, SIZE_W'(MAX_ROWS));

  // Normalize the stored position against the current sizes
  always_comb begin
    col_wrap = {1'b0, col} >= w;
    row_a    = col_wrap ? row + ROW_W'(1) : row;
    h_p1     = {1'b0, ROW_W'(h)} + (ROW_W+1)'(1);
    restart  = {1'b0, row_a} > h_p1;
    ir       = restart ? '0 : row_a;
    ic       = (restart || col_wrap) ? '0 : col;
    ir_m1    = ir - ROW_W'(1);
    ir_m2    = ir - ROW_W'(2);
    w_m1     = w - SIZE_W'(1);
  end

  // Per-item decisions
  always_comb begin
    info.ic       = ic;
    info.bot      = (ROW_W'(h) > ir) && !kind && cell_req;
    info.mid_en   = ir != '0;
    info.top_en   = ir >= ROW_W'(2);
    info.col_zero = ic == '0;
    info.fin      = (ic == '0) && ({1'b0, ir} == h_p1);
    if (ic == '0) begin
      info.emit    = ir >= ROW_W'(2);
      info.out_row = ir_m2[OUT_W-1:0];
      info.out_col = w_m1[OUT_W-1:0];
    end else begin
      info.emit    = (ir != '0) && (ir <= ROW_W'(h));
      info.out_row = ir_m1[OUT_W-1:0];
      info.out_col = OUT_W'(ic - COL_W'(1));
    end
  end

  // Advance the position past the accepted item
  always_comb begin
    col_inc  = {1'b0, ic} + SIZE_W'(1);
    row_next = ir;
    col_next = col_inc[COL_W-1:0];
    if (info.fin) begin
      row_next = '0;
      col_next = '0;
    end else if (col_inc >= w) begin
      row_next = ir + ROW_W'(1);
      col_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

// ===== hw/rtl/casp_lines.sv =====
`timescale 1ns / 1ps
// Two line stores packed in one memory, one entry per column, with valid
// bits for the all-floor reset state and write-to-read forwarding.
// Depends on casp_pkg.
module casp_lines (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [casp_pkg::COL_W-1:0]  rd_addr,
  input  logic                        wr_en,
  input  logic [casp_pkg::COL_W-1:0]  wr_addr,
  input  casp_pkg::line_word_t        wr_data,
  output casp_pkg::line_word_t        rd_data
);
  import casp_pkg::*;

  line_word_t          mem [MAX_COLS];
  logic [MAX_COLS-1:0] vld;

  // Memory write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entry valid bits, cleared at reset so untouched columns read as floor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Registered read; a write to the same column in this cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (vld[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/casp_window.sv =====
`timescale 1ns / 1ps
// 3x3 window shift register, neighbor count and wall decision.
// Depends on casp_pkg.
module casp_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        col_zero,
  input  logic [2:0]                  col,        // {bot, mid, top}
  input  logic [casp_pkg::THR_W-1:0]  threshold,
  output logic                        new_cell
);
  import casp_pkg::*;

  logic [8:0]       window, window_next, win;
  logic [CNT_W-1:0] count;

  // Shift in the new column; at a row start the old right column is finished
  // against a floor edge and the window restarts from the new column
  always_comb begin
    if (col_zero) begin
      win         = {3'b000, window[8:3]};
      window_next = {col, 6'b000000};
    end else begin
      window_next = {col, window[8:3]};
      win         = window_next;
    end
  end

  // Count walls around the centre, centre excluded
  always_comb begin
    count = '0;
    for (int b = 0; b < 9; b++) begin
      if (b != 4) count = count + CNT_W'(win[b]);
    end
    new_cell = count > threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (adv) begin
      window <= window_next;
    end
  end

endmodule

// ===== hw/rtl/casp_out_buf.sv =====
`timescale 1ns / 1ps
// Two-word result buffer; its full flag is registered so the input side
// never waits on the result channel's ready in the same cycle.
// Depends on casp_pkg and casp_if.
module casp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  casp_pkg::res_t   push_data,
  output logic             full,
  casp_res_if.source       results
);
  import casp_pkg::*;

  res_t       head, tail;
  logic [1:0] count;
  logic       pop;

  assign pop  = results.valid && results.ready;
  assign full = count == 2'd2;

  assign results.valid    = count != 2'd0;
  assign results.new_cell = head.new_cell;
  assign results.out_row  = head.out_row;
  assign results.out_col  = head.out_col;
  assign results.last     = head.last;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Word storage
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) head <= push_data;
        else tail <= push_data;
      end
      2'b01: begin
        head <= tail;
      end
      2'b11: begin
        if (count == 2'd1) begin
          head <= push_data;
        end else begin
          head <= tail;
          tail <= push_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/cave_automaton_smoothing_pass.sv =====
`timescale 1ns / 1ps
// Cave smoothing, one generation over a raster stream of cells.
// Throughput: one word per cycle unless the result buffer is full. A cell's result
// follows the word that completes its neighborhood through the position stage, then
// the line-store read and window stage, one row plus one cell behind the input.
// Reset (rst, synchronous): registers to 150/150/4, position and window to
// zero, line-store valid bits cleared at once; no clearing pass is needed.
module cave_automaton_smoothing_pass (
  input  logic        clk,
  input  logic        rst,
  casp_cfg_if.sink    cfg,
  casp_cell_if.sink   cells,
  casp_res_if.source  results
);
  import casp_pkg::*;

  logic [SIZE_W-1:0] grid_width, grid_height;
  logic [THR_W-1:0]  wall_threshold;

  pos_t       pos_info, s1_info;
  logic       s1_valid, s1_adv, s1_fire;
  logic       accept_in;
  logic       buf_full;
  line_word_t rd_word, wr_word;
  logic       mid, top;
  logic       new_cell;
  res_t       res_word;

  // Configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= RESET_SIZE;
      grid_height    <= RESET_SIZE;
      wall_threshold <= RESET_THRESHOLD;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GRID_WIDTH:     grid_width     <= cfg.data[SIZE_W-1:0];
        REG_GRID_HEIGHT:    grid_height    <= cfg.data[SIZE_W-1:0];
        REG_WALL_THRESHOLD: wall_threshold <= cfg.data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: stage 1 moves on unless its word finds the buffer full
  assign s1_adv      = !buf_full || !s1_info.emit;
  assign s1_fire     = s1_valid && s1_adv;
  assign cells.ready = !s1_valid || s1_adv;
  assign accept_in   = cells.valid && cells.ready;

  // Position stage
  casp_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .kind        (cells.kind),
    .cell_req    (cells.cell_req),
    .accept      (accept_in),
    .info        (pos_info)
  );

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_info <= pos_info;
    end
  end

  // Line stores: read at accept, rewrite the column when stage 1 moves on
  assign mid     = s1_info.mid_en && rd_word.lower;
  assign top     = s1_info.top_en && rd_word.upper;
  assign wr_word = '{upper: mid, lower: s1_info.bot};

  casp_lines u_lines (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept_in),
    .rd_addr (pos_info.ic),
    .wr_en   (s1_fire),
    .wr_addr (s1_info.ic),
    .wr_data (wr_word),
    .rd_data (rd_word)
  );

  // Window and decision
  casp_window u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (s1_fire),
    .col_zero  (s1_info.col_zero),
    .col       ({s1_info.bot, mid, top}),
    .threshold (wall_threshold),
    .new_cell  (new_cell)
  );

  // Result buffer
  assign res_word = '{new_cell: new_cell, out_row: s1_info.out_row,
                      out_col: s1_info.out_col, last: s1_info.fin};

  casp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_fire && s1_info.emit),
    .push_data (res_word),
    .full      (buf_full),
    .results   (results)
  );

  // The final cell of a grid always produces a word
  a_fin_emits: assert property (@(posedge clk) disable iff (rst)
    accept_in && pos_info.fin |-> pos_info.emit)
    else $error("final cell without a result word");

  // A held stage 1 keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_info))
    else $error("stage 1 item lost while stalled");

  // Input stalls only behind a blocked stage 1
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !cells.ready |-> s1_valid && buf_full)
    else $error("input stalled without cause");

endmodule
